FILE: hdl/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types and constants of the bilinear texture sampler.
// ----------------------------------------------------------------------------
package bts_pkg;

    localparam int ADDR_W   = 16;
    localparam int CH_W     = 8;
    localparam int TEXEL_W  = 3 * CH_W;
    localparam int SIZE_W   = 9;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int STORE_DEPTH = 1 << ADDR_W;

    localparam logic [SIZE_W-1:0] RESET_SIZE = 9'd256;

    // Operation codes of an input transaction.
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // Register indexes (paddr[2]).
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Status codes of a result transaction.
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // Stage enables of the blend unit.
    typedef struct packed {
        logic en_prod;
        logic en_sum;
    } blend_ctrl_t;

endpackage

FILE: hdl/bts_in_if.sv
// ----------------------------------------------------------------------------
// bts_in_if / bts_out_if
// Valid/ready channels for load and sample requests and for results.
// ----------------------------------------------------------------------------
interface bts_in_if #(parameter int FRAC_BITS = 16);
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [15:0]          texel_address;
    logic [7:0]           texel_red;
    logic [7:0]           texel_green;
    logic [7:0]           texel_blue;
    logic [FRAC_BITS:0]   coord_u;
    logic [FRAC_BITS:0]   coord_v;

    modport source (output valid, func, texel_address, texel_red, texel_green,
                    texel_blue, coord_u, coord_v, input ready);
    modport sink   (input valid, func, texel_address, texel_red, texel_green,
                    texel_blue, coord_u, coord_v, output ready);
endinterface

interface bts_out_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, status, red, green, blue, input ready);
    modport sink   (input valid, status, red, green, blue, output ready);
endinterface

FILE: hdl/bts_ram.sv
// ----------------------------------------------------------------------------
// bts_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[waddr] <= wdata;
            end
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

FILE: hdl/bts_cfg.sv
// ----------------------------------------------------------------------------
// bts_cfg
// APB register file for the texture size, with the sizes clamped for use.
// ----------------------------------------------------------------------------
module bts_cfg #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [bts_pkg::PADDR_W-1:0]      paddr,
    input  logic [bts_pkg::PDATA_W-1:0]      pwdata,
    output logic [bts_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready,
    output logic [$clog2(MAX_WIDTH+1)-1:0]   width,
    output logic [$clog2(MAX_HEIGHT+1)-1:0]  height
);
    import bts_pkg::*;

    localparam int SW = $clog2(MAX_WIDTH + 1);
    localparam int SH = $clog2(MAX_HEIGHT + 1);

    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_SIZE;
            height_reg <= RESET_SIZE;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_WIDTH:  width_reg  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[SIZE_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_HEIGHT: prdata = PDATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // A size of zero counts as one, a size above the maximum as the maximum.
    always_comb
    begin
        if (width_reg == '0)
            width = SW'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            width = SW'(MAX_WIDTH);
        else
            width = SW'(width_reg);

        if (height_reg == '0)
            height = SH'(1);
        else if (int'(height_reg) > MAX_HEIGHT)
            height = SH'(MAX_HEIGHT);
        else
            height = SH'(height_reg);
    end

endmodule

FILE: hdl/bts_blend.sv
// ----------------------------------------------------------------------------
// bts_blend
// Two-stage weighted sum of four corner texels with rounding per channel.
// ----------------------------------------------------------------------------
module bts_blend #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  bts_pkg::blend_ctrl_t        ctrl,
    input  logic                        kill,
    input  logic [bts_pkg::TEXEL_W-1:0] tex_ff,
    input  logic [bts_pkg::TEXEL_W-1:0] tex_fc,
    input  logic [bts_pkg::TEXEL_W-1:0] tex_cf,
    input  logic [bts_pkg::TEXEL_W-1:0] tex_cc,
    input  logic [2*FRAC_BITS+1:0]      w_ff,
    input  logic [2*FRAC_BITS+1:0]      w_fc,
    input  logic [2*FRAC_BITS+1:0]      w_cf,
    input  logic [2*FRAC_BITS+1:0]      w_cc,
    output logic [bts_pkg::TEXEL_W-1:0] color
);
    import bts_pkg::*;

    localparam int WT_W = 2 * FRAC_BITS + 2;
    localparam int P_W  = WT_W + CH_W;
    localparam int S_W  = P_W + 2;
    localparam int R_W  = S_W - 2 * FRAC_BITS;
    localparam logic [S_W-1:0] HALF = S_W'(1) << (2 * FRAC_BITS - 1);
    localparam logic [CH_W-1:0] CH_MAX = '1;

    logic [P_W-1:0]     prod_reg [3][4];
    logic               kill_reg;
    logic [TEXEL_W-1:0] color_reg;
    logic [TEXEL_W-1:0] color_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.en_prod)
        begin
            kill_reg <= kill;
            for (int c = 0; c < 3; c++)
            begin
                prod_reg[c][0] <= P_W'(tex_ff[c*CH_W +: CH_W]) * P_W'(w_ff);
                prod_reg[c][1] <= P_W'(tex_fc[c*CH_W +: CH_W]) * P_W'(w_fc);
                prod_reg[c][2] <= P_W'(tex_cf[c*CH_W +: CH_W]) * P_W'(w_cf);
                prod_reg[c][3] <= P_W'(tex_cc[c*CH_W +: CH_W]) * P_W'(w_cc);
            end
        end
    end

    always_comb
    begin
        logic [S_W-1:0] sum;
        logic [R_W-1:0] rnd;
        color_next = '0;
        for (int c = 0; c < 3; c++)
        begin
            sum = S_W'(prod_reg[c][0]) + S_W'(prod_reg[c][1])
                + S_W'(prod_reg[c][2]) + S_W'(prod_reg[c][3]) + HALF;
            rnd = sum[S_W-1:2*FRAC_BITS];
            if (kill_reg)
                color_next[c*CH_W +: CH_W] = '0;
            else if (rnd > R_W'(CH_MAX))
                color_next[c*CH_W +: CH_W] = CH_MAX;
            else
                color_next[c*CH_W +: CH_W] = rnd[CH_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_sum)
        begin
            color_reg <= color_next;
        end
    end

    assign color = color_reg;

endmodule

FILE: hdl/bilinear_texture_sampler.sv
// ----------------------------------------------------------------------------
// bilinear_texture_sampler
// Six-stage pipeline that loads texels and samples them bilinearly.
// ----------------------------------------------------------------------------
// Channel     Dir   Contents
// sample_in   in    func, texel_address, texel rgb, coord_u, coord_v
// result_out  out   status, red, green, blue
// apb         in    texture_width (0x0), texture_height (0x4)
//
// One transaction per cycle while the result channel is ready; a result is
// presented once its request has passed through every stage register.
// Stages: input, coordinate scale, split and row multiply, address and
// weights with the texel RAM read, corner products, sum and rounding.
// Loads write the RAM in the same stage in which samples read it, so order
// is kept. Each stage holds under backpressure and empty stages still fill.
// Reset clears the valid bits and sets the size registers to 256 only; the
// texel store is undefined until written.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    bts_in_if.sink                      sample_in,
    bts_out_if.source                   result_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bts_pkg::PADDR_W-1:0] paddr,
    input  logic [bts_pkg::PDATA_W-1:0] pwdata,
    output logic [bts_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import bts_pkg::*;

    localparam int SW    = $clog2(MAX_WIDTH + 1);
    localparam int SH    = $clog2(MAX_HEIGHT + 1);
    localparam int F     = FRAC_BITS;
    localparam int C_W   = F + 1;
    localparam int WT_W  = 2 * F + 2;
    localparam int SU_W  = C_W + SW;
    localparam int SV_W  = C_W + SH;
    localparam int ROW_W = SH + SW;
    localparam int SUM_W = (ROW_W + 1 > ADDR_W) ? ROW_W + 1 : ADDR_W;
    localparam logic [C_W-1:0] ONE = C_W'(1) << F;

    logic [SW-1:0] width;
    logic [SH-1:0] height;

    bts_cfg #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .width  (width),
        .height (height)
    );

    // Valid bits and stage enables.
    logic [6:1] v_reg;
    logic [7:1] en;

    assign en[7] = result_out.ready;
    always_comb
    begin
        for (int k = 1; k <= 6; k++)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign sample_in.ready = en[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1]) v_reg[1] <= sample_in.valid;
            for (int k = 2; k <= 6; k++)
            begin
                if (en[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // Stage 1: input register.
    logic               func1_reg;
    logic [ADDR_W-1:0]  addr1_reg;
    logic [TEXEL_W-1:0] texel1_reg;
    logic [C_W-1:0]     u1_reg;
    logic [C_W-1:0]     cv1_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            func1_reg  <= sample_in.func;
            addr1_reg  <= sample_in.texel_address;
            texel1_reg <= {sample_in.texel_red, sample_in.texel_green,
                           sample_in.texel_blue};
            u1_reg     <= sample_in.coord_u;
            cv1_reg    <= sample_in.coord_v;
        end
    end

    // Stage 2: range check and coordinate scaling.
    logic               func2_reg;
    logic               kill2_reg;
    logic [ADDR_W-1:0]  addr2_reg;
    logic [TEXEL_W-1:0] texel2_reg;
    logic [SU_W-1:0]    su2_reg;
    logic [SV_W-1:0]    sv2_reg;
    logic               range_next;

    assign range_next = (u1_reg > ONE) || (cv1_reg > ONE);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            func2_reg  <= func1_reg;
            kill2_reg  <= (func1_reg == FUNC_LOAD) || range_next;
            addr2_reg  <= addr1_reg;
            texel2_reg <= texel1_reg;
            su2_reg    <= SU_W'(u1_reg) * SU_W'(width - SW'(1));
            sv2_reg    <= SV_W'(cv1_reg) * SV_W'(height - SH'(1));
        end
    end

    // Stage 3: floor, ceiling, fraction and row offsets.
    logic [SW-1:0] u0_next;
    logic [SW-1:0] u1_next;
    logic [SH-1:0] v0_next;
    logic [SH-1:0] v1_next;
    logic [F-1:0]  du_next;
    logic [F-1:0]  dv_next;

    assign u0_next = su2_reg[F +: SW];
    assign du_next = su2_reg[F-1:0];
    assign u1_next = u0_next + SW'(du_next != '0);
    assign v0_next = sv2_reg[F +: SH];
    assign dv_next = sv2_reg[F-1:0];
    assign v1_next = v0_next + SH'(dv_next != '0);

    logic               func3_reg;
    logic               kill3_reg;
    logic               status3_reg;
    logic [ADDR_W-1:0]  addr3_reg;
    logic [TEXEL_W-1:0] texel3_reg;
    logic [SW-1:0]      u0_reg;
    logic [SW-1:0]      u1_reg3;
    logic [F-1:0]       du_reg;
    logic [F-1:0]       dv_reg;
    logic [ROW_W-1:0]   row0_reg;
    logic [ROW_W-1:0]   row1_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            func3_reg   <= func2_reg;
            kill3_reg   <= kill2_reg;
            status3_reg <= (func2_reg == FUNC_SAMPLE) && kill2_reg
                           ? STATUS_RANGE : STATUS_OK;
            addr3_reg   <= addr2_reg;
            texel3_reg  <= texel2_reg;
            u0_reg      <= u0_next;
            u1_reg3     <= u1_next;
            du_reg      <= du_next;
            dv_reg      <= dv_next;
            row0_reg    <= ROW_W'(v0_next) * ROW_W'(width);
            row1_reg    <= ROW_W'(v1_next) * ROW_W'(width);
        end
    end

    // Stage 4: corner addresses, texel RAM access and weights.
    logic [SUM_W-1:0]  sum_ff;
    logic [SUM_W-1:0]  sum_fc;
    logic [SUM_W-1:0]  sum_cf;
    logic [SUM_W-1:0]  sum_cc;
    logic [C_W-1:0]    du_ext;
    logic [C_W-1:0]    dv_ext;
    logic [C_W-1:0]    omdu;
    logic [C_W-1:0]    omdv;
    logic              ram_we;
    logic [TEXEL_W-1:0] tex_ff;
    logic [TEXEL_W-1:0] tex_fc;
    logic [TEXEL_W-1:0] tex_cf;
    logic [TEXEL_W-1:0] tex_cc;

    assign sum_ff = SUM_W'(row0_reg) + SUM_W'(u0_reg);
    assign sum_fc = SUM_W'(row0_reg) + SUM_W'(u1_reg3);
    assign sum_cf = SUM_W'(row1_reg) + SUM_W'(u0_reg);
    assign sum_cc = SUM_W'(row1_reg) + SUM_W'(u1_reg3);
    assign du_ext = C_W'(du_reg);
    assign dv_ext = C_W'(dv_reg);
    assign omdu   = ONE - du_ext;
    assign omdv   = ONE - dv_ext;
    assign ram_we = v_reg[3] && (func3_reg == FUNC_LOAD);

    // Two copies of the store give four reads per cycle while stage 4 is enabled.
    bts_ram #(
        .WIDTH(TEXEL_W),
        .DEPTH(STORE_DEPTH)
    ) u_ram_floor (
        .clk    (clk),
        .en     (en[4]),
        .we     (ram_we),
        .waddr  (addr3_reg),
        .wdata  (texel3_reg),
        .raddr_a(sum_ff[ADDR_W-1:0]),
        .raddr_b(sum_fc[ADDR_W-1:0]),
        .rdata_a(tex_ff),
        .rdata_b(tex_fc)
    );

    bts_ram #(
        .WIDTH(TEXEL_W),
        .DEPTH(STORE_DEPTH)
    ) u_ram_ceil (
        .clk    (clk),
        .en     (en[4]),
        .we     (ram_we),
        .waddr  (addr3_reg),
        .wdata  (texel3_reg),
        .raddr_a(sum_cf[ADDR_W-1:0]),
        .raddr_b(sum_cc[ADDR_W-1:0]),
        .rdata_a(tex_cf),
        .rdata_b(tex_cc)
    );

    logic            kill4_reg;
    logic            status4_reg;
    logic [WT_W-1:0] w_ff_reg;
    logic [WT_W-1:0] w_fc_reg;
    logic [WT_W-1:0] w_cf_reg;
    logic [WT_W-1:0] w_cc_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            kill4_reg   <= kill3_reg;
            status4_reg <= status3_reg;
            w_cc_reg    <= WT_W'(du_ext) * WT_W'(dv_ext);
            w_fc_reg    <= WT_W'(du_ext) * WT_W'(omdv);
            w_cf_reg    <= WT_W'(omdu) * WT_W'(dv_ext);
            w_ff_reg    <= WT_W'(omdu) * WT_W'(omdv);
        end
    end

    // Stages 5 and 6: corner products, then sum and rounding.
    blend_ctrl_t        blend_ctrl;
    logic [TEXEL_W-1:0] color;
    logic               status5_reg;
    logic               status6_reg;

    assign blend_ctrl.en_prod = en[5];
    assign blend_ctrl.en_sum  = en[6];

    bts_blend #(
        .FRAC_BITS(FRAC_BITS)
    ) u_blend (
        .clk   (clk),
        .ctrl  (blend_ctrl),
        .kill  (kill4_reg),
        .tex_ff(tex_ff),
        .tex_fc(tex_fc),
        .tex_cf(tex_cf),
        .tex_cc(tex_cc),
        .w_ff  (w_ff_reg),
        .w_fc  (w_fc_reg),
        .w_cf  (w_cf_reg),
        .w_cc  (w_cc_reg),
        .color (color)
    );

    always_ff @(posedge clk)
    begin
        if (en[5]) status5_reg <= status4_reg;
        if (en[6]) status6_reg <= status5_reg;
    end

    assign result_out.valid  = v_reg[6];
    assign result_out.status = status6_reg;
    assign result_out.red    = color[2*CH_W +: CH_W];
    assign result_out.green  = color[CH_W +: CH_W];
    assign result_out.blue   = color[0 +: CH_W];

endmodule

FILE: tb/sv/bilinear_texture_sampler_tb.sv
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_tb
// Self-checking bench for the bilinear texture sampler. Loads texels, samples
// them under several texture sizes, and compares every result transaction
// with a bit-exact software prediction of the bilinear blend.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bts_pkg::*;

    localparam int FRAC = 16;
    localparam int ONE = 1 << FRAC;

    typedef struct packed {
        logic       status;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } texel_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    bts_in_if #(.FRAC_BITS(FRAC)) req_ch ();
    bts_out_if res_ch ();

    bilinear_texture_sampler u_top (
        .clk(clk), .rst_n(rst_n), .sample_in(req_ch.sink), .result_out(res_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 clk = ~clk;

    // Shadow of the texture and the size registers.
    logic [23:0] texel_mem [int unsigned];
    int unsigned tex_w = 256, tex_h = 256;
    texel_result_t pending_colors [$];
    int errors = 0;
    int hold_cycles = 0;
    int hold_req = 0;
    int hold_seen = 0;
    bit no_idle = 1'b0;
    int loaded_w = 1, loaded_h = 1;

    function automatic int unsigned eff_size(int unsigned s);
        if (s < 1) return 1;
        if (s > 256) return 256;
        return s;
    endfunction

    function automatic logic [7:0] blend_channel(int sh, logic [15:0] a [4],
                                                 longint unsigned wt [4]);
        longint unsigned acc;
        acc = 0;
        for (int k = 0; k < 4; k++)
            acc += longint'(texel_mem[a[k]][sh +: 8]) * wt[k];
        acc = (acc + (64'd1 << (2 * FRAC - 1))) >> (2 * FRAC);
        return (acc > 255) ? 8'd255 : acc[7:0];
    endfunction

    function automatic texel_result_t predict_color(logic [16:0] u, logic [16:0] v);
        texel_result_t r;
        int unsigned w, h, u0, u1, v0, v1;
        longint unsigned su, sv, du, dv;
        logic [15:0] a [4];
        longint unsigned wt [4];
        r = '0;
        if (u > ONE || v > ONE)
        begin
            r.status = STATUS_RANGE;
            return r;
        end
        w = eff_size(tex_w);
        h = eff_size(tex_h);
        su = longint'(u) * 64'(w - 1);
        sv = longint'(v) * 64'(h - 1);
        u0 = 32'(su >> FRAC); du = su & 64'(ONE - 1); u1 = u0 + 32'(du != 0);
        v0 = 32'(sv >> FRAC); dv = sv & 64'(ONE - 1); v1 = v0 + 32'(dv != 0);
        a[0] = 16'(v0 * w + u0); a[1] = 16'(v0 * w + u1);
        a[2] = 16'(v1 * w + u0); a[3] = 16'(v1 * w + u1);
        wt[0] = (ONE - du) * (ONE - dv); wt[1] = du * (ONE - dv);
        wt[2] = (ONE - du) * dv;         wt[3] = du * dv;
        r.status = STATUS_OK;
        r.red = blend_channel(16, a, wt);
        r.green = blend_channel(8, a, wt);
        r.blue = blend_channel(0, a, wt);
        return r;
    endfunction

    task automatic idle_gap();
        while (!no_idle && $urandom_range(99) < 22)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Sends one transaction and records what it must produce.
    task automatic send_item(logic func, logic [15:0] addr, logic [23:0] rgb,
                             logic [16:0] u, logic [16:0] v);
        texel_result_t r;
        idle_gap();
        req_ch.valid <= 1'b1;
        req_ch.func <= func;
        req_ch.texel_address <= addr;
        {req_ch.texel_red, req_ch.texel_green, req_ch.texel_blue} <= rgb;
        req_ch.coord_u <= u;
        req_ch.coord_v <= v;
        do @(posedge clk); while (!req_ch.ready);
        if (func == FUNC_LOAD)
        begin
            texel_mem[addr] = rgb;
            r = '0;
        end
        else
            r = predict_color(u, v);
        pending_colors.push_back(r);
    endtask

    task automatic write_reg(logic idx, int unsigned value);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_WIDTH) tex_w = value & 9'h1FF;
        else tex_h = value & 9'h1FF;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        req_ch.valid <= 1'b0;
        while (pending_colors.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
    endtask

    // Changes the size and fills every texel that a sample can reach.
    task automatic set_texture(int unsigned w, int unsigned h);
        drain();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        loaded_w = int'(eff_size(tex_w));
        loaded_h = int'(eff_size(tex_h));
        for (int i = 0; i < loaded_w * loaded_h; i++)
            send_item(FUNC_LOAD, i[15:0], 24'($urandom), 17'($urandom), 17'($urandom));
    endtask

    function automatic logic [16:0] rand_coord();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return 17'(ONE);
        if (sel == 1) return 17'(ONE + 1 + $urandom_range(ONE - 2));
        if (sel == 2) return 17'h1FFFF;
        if (sel == 3) return 17'd0;
        return 17'($urandom_range(ONE - 1));
    endfunction

    task automatic test_directed();
        set_texture(4, 3);
        send_item(FUNC_SAMPLE, 16'($urandom), 24'($urandom), 17'd0, 17'd0);
        send_item(FUNC_SAMPLE, 16'($urandom), 24'($urandom), 17'(ONE), 17'(ONE));
        send_item(FUNC_SAMPLE, 16'($urandom), 24'($urandom), 17'(ONE), 17'd0);
        send_item(FUNC_SAMPLE, 16'($urandom), 24'($urandom), 17'd0, 17'(ONE));
        send_item(FUNC_SAMPLE, 16'($urandom), 24'($urandom), 17'h8000, 17'h8000);
        send_item(FUNC_SAMPLE, 16'($urandom), 24'($urandom), 17'(ONE + 1), 17'd0);
        send_item(FUNC_SAMPLE, 16'($urandom), 24'($urandom), 17'd0, 17'h1FFFF);
        send_item(FUNC_SAMPLE, 16'($urandom), 24'($urandom), 17'h1FFFF, 17'h1FFFF);
        send_item(FUNC_SAMPLE, 16'($urandom), 24'($urandom), 17'hFFFF, 17'h0001);
        // Extreme data values and the top address of the store.
        send_item(FUNC_LOAD, 16'hFFFF, 24'hFFFFFF, 17'h1FFFF, 17'h1FFFF);
        send_item(FUNC_LOAD, 16'd0, 24'hFFFFFF, '0, '0);
        send_item(FUNC_SAMPLE, 16'hFFFF, 24'hFFFFFF, 17'd0, 17'd0);
        send_item(FUNC_LOAD, 16'd0, 24'h000000, '0, '0);
        send_item(FUNC_SAMPLE, '0, '0, 17'h4000, 17'hC000);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) < 2)
                send_item(FUNC_LOAD, 16'($urandom_range(loaded_w * loaded_h - 1)),
                          24'($urandom), 17'($urandom), 17'($urandom));
            else
                send_item(FUNC_SAMPLE, 16'($urandom), 24'($urandom),
                          rand_coord(), rand_coord());
        end
    endtask

    // A zero size counts as one and an oversize width or height as the maximum.
    task automatic test_sizes();
        set_texture(0, 511);
        test_random(20);
        set_texture(511, 0);
        test_random(20);
        set_texture(9, 7);
        test_random(100);
        set_texture(1, 1);
        test_random(30);
        set_texture(2, 2);
        test_random(40);
    endtask

    task automatic test_backpressure();
        set_texture($urandom_range(2, 16), $urandom_range(2, 16));
        hold_req++;
        test_random(80);
        no_idle = 1'b1;
        test_random(150);
        no_idle = 1'b0;
        set_texture($urandom_range(3, 12), $urandom_range(3, 12));
        test_random(150);
    endtask

    always @(posedge clk)
    begin
        texel_result_t got, exp_r;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = {res_ch.status, res_ch.red, res_ch.green, res_ch.blue};
            if (pending_colors.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("Unexpected result %h", got);
            end
            else
            begin
                exp_r = pending_colors.pop_front();
                if (got !== exp_r)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"Mismatch: expected st=%0d rgb=%h_%h_%h ",
                                  "got st=%0d rgb=%h_%h_%h"},
                                 exp_r.status, exp_r.red, exp_r.green, exp_r.blue,
                                 got.status, got.red, got.green, got.blue);
                end
            end
        end
    end

    // Result-side ready; a requested hold keeps it low for a long stretch.
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_cycles <= 60;
            res_ch.ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= no_idle || ($urandom_range(99) >= 22);
    end

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.func = FUNC_LOAD;
        req_ch.texel_address = '0;
        req_ch.texel_red = '0;
        req_ch.texel_green = '0;
        req_ch.texel_blue = '0;
        req_ch.coord_u = '0;
        req_ch.coord_v = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_sizes();
        test_backpressure();
        drain();
        if (errors == 0 && pending_colors.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end
endmodule
